// ----- sv/assert_macros.svh -----
// Assertion macros shared by the reorder receiver RTL.
// Needs clk and rst in scope; rst high disables every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/rrae_pkg.sv -----
// Package for the reorder receiver ack engine: widths, codes, beat types.
// No dependencies; the top, front and engine use it by scoped names.
package rrae_pkg;

  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 11;
  localparam int ACTION_W   = 2;
  localparam int SLOT_IDX_W = 4;
  localparam int STATUS_W   = 3;

  localparam int BUFFER_SLOTS_DEF = 16;
  localparam int MID_DEPTH        = 2;
  localparam int OUT_DEPTH        = 4;

  // Result actions
  localparam logic [ACTION_W-1:0] ACT_DELIVER_IN   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELIVER_SLOT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ACK          = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FINAL        = 2'd3;

  // Store status on an out-of-order ack
  localparam logic [STATUS_W-1:0] ST_NONE   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STORED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STALE  = 3'd4;

  // Classified segment header between front and engine
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic             is_final;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [SEQ_W-1:0]      deliver_offset;
    logic [LEN_W-1:0]      deliver_length;
    logic [SEQ_W-1:0]      ack_number;
    logic [STATUS_W-1:0]   store_status;
    logic                  last;
  } result_t;

  // Engine sequencer states
  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_CHECK,
    ENG_DECIDE,
    ENG_SEARCH,
    ENG_PICK,
    ENG_DRAIN,
    ENG_ACK
  } eng_state_t;

endpackage

// ----- sv/reorder_receiver_ack_engine_top.sv -----
// Top level of the reorder receiver ack engine: front queue, engine, result queue.
// Depends on rrae_pkg, rrae_front, rrae_engine, rrae_fifo.
//
//   side     handshake        beat fields
//   input    push / full      seq_number, payload_length
//   result   empty / pop      action, slot_index, deliver_offset, deliver_length,
//                             ack_number, store_status, last
//
// In the engine, end-of-transfer and out-of-order headers go through check and decide;
// an in-order header then repeats search, pick and drain for each drained slot (one
// slot-table search and one length RAM read per drained slot) and ends in ack.
// Synchronous reset clears the expected offset, slot valid bits and both queues.
// The engine halts while the result queue is full; the input queue keeps accepting
// headers until it fills.
module reorder_receiver_ack_engine_top #(
  parameter int BUFFER_SLOTS = rrae_pkg::BUFFER_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [rrae_pkg::SEQ_W-1:0]      seq_number,
  input  logic [rrae_pkg::LEN_W-1:0]      payload_length,
  output logic                            empty,
  input  logic                            pop,
  output logic [rrae_pkg::ACTION_W-1:0]   action,
  output logic [rrae_pkg::SLOT_IDX_W-1:0] slot_index,
  output logic [rrae_pkg::SEQ_W-1:0]      deliver_offset,
  output logic [rrae_pkg::LEN_W-1:0]      deliver_length,
  output logic [rrae_pkg::SEQ_W-1:0]      ack_number,
  output logic [rrae_pkg::STATUS_W-1:0]   store_status,
  output logic                            last
);

  logic                                 mid_pop;
  logic                                 mid_empty;
  rrae_pkg::item_t                      mid_item;
  logic                                 out_full;
  logic                                 out_push;
  rrae_pkg::result_t                    out_res;
  logic [$bits(rrae_pkg::result_t)-1:0] head_bits;
  rrae_pkg::result_t                    head;

  rrae_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .seq_number    (seq_number),
    .payload_length(payload_length),
    .full          (full),
    .mid_pop       (mid_pop),
    .mid_empty     (mid_empty),
    .mid_item      (mid_item)
  );

  rrae_engine #(
    .BUFFER_SLOTS(BUFFER_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .mid_empty(mid_empty),
    .mid_item (mid_item),
    .mid_pop  (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_res  (out_res)
  );

  rrae_fifo #(
    .WIDTH($bits(rrae_pkg::result_t)),
    .DEPTH(rrae_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (out_push),
    .wr_data(out_res),
    .full   (out_full),
    .pop    (pop),
    .rd_data(head_bits),
    .empty  (empty)
  );

  // Unpack the oldest result beat
  assign head           = rrae_pkg::result_t'(head_bits);
  assign action         = head.action;
  assign slot_index     = head.slot_index;
  assign deliver_offset = head.deliver_offset;
  assign deliver_length = head.deliver_length;
  assign ack_number     = head.ack_number;
  assign store_status   = head.store_status;
  assign last           = head.last;

endmodule

// ----- sv/rrae_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/rrae_fifo.sv -----
// Small flop-based queue with push/full and pop/empty sides.
// Uses assert_macros.svh.
`include "assert_macros.svh"
module rrae_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entry[rd_ptr];

  // Store a beat at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))

endmodule

// ----- sv/rrae_front.sv -----
// Front end: accepts segment headers, flags end of transfer, queues them.
// Depends on rrae_pkg and rrae_fifo.
module rrae_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [rrae_pkg::SEQ_W-1:0] seq_number,
  input  logic [rrae_pkg::LEN_W-1:0] payload_length,
  output logic                      full,
  input  logic                      mid_pop,
  output logic                      mid_empty,
  output rrae_pkg::item_t           mid_item
);

  rrae_pkg::item_t                  in_item;
  logic [$bits(rrae_pkg::item_t)-1:0] rd_bits;

  // Classify: zero length ends the transfer
  always_comb begin
    in_item.seq      = seq_number;
    in_item.len      = payload_length;
    in_item.is_final = (payload_length == '0);
  end

  rrae_fifo #(
    .WIDTH($bits(rrae_pkg::item_t)),
    .DEPTH(rrae_pkg::MID_DEPTH)
  ) u_mid_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(in_item),
    .full   (full),
    .pop    (mid_pop),
    .rd_data(rd_bits),
    .empty  (mid_empty)
  );

  assign mid_item = rrae_pkg::item_t'(rd_bits);

endmodule

// ----- sv/rrae_engine.sv -----
// Back end: expected offset, slot table (match cells plus length RAM),
// delivery, drain and ack sequencing. Depends on rrae_pkg, rrae_ram.
`include "assert_macros.svh"
module rrae_engine #(
  parameter int BUFFER_SLOTS = rrae_pkg::BUFFER_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_empty,
  input  rrae_pkg::item_t   mid_item,
  output logic              mid_pop,
  input  logic              out_full,
  output logic              out_push,
  output rrae_pkg::result_t out_res
);

  localparam int SLOT_W = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
  localparam int SEQ_W  = rrae_pkg::SEQ_W;
  localparam int LEN_W  = rrae_pkg::LEN_W;
  localparam int IDX_W  = rrae_pkg::SLOT_IDX_W;

  rrae_pkg::eng_state_t state;
  rrae_pkg::eng_state_t state_next;

  logic [SEQ_W-1:0]        cur_seq;
  logic [LEN_W-1:0]        cur_len;
  logic                    cur_final;
  logic [SEQ_W-1:0]        expected_seq;
  logic [BUFFER_SLOTS-1:0] slot_valid;
  logic [SEQ_W-1:0]        slot_seq [BUFFER_SLOTS];
  logic [BUFFER_SLOTS-1:0] hit_vec;
  logic                    is_eq;
  logic                    is_stale;
  logic [SLOT_W-1:0]       hit_idx;

  logic [SEQ_W-1:0]        cmp_key;
  logic [BUFFER_SLOTS-1:0] match;
  logic [SLOT_W-1:0]       first_hit;
  logic [SLOT_W-1:0]       first_free;
  logic                    any_free;
  logic [LEN_W-1:0]        ram_len;

  logic                    latch_item;
  logic                    latch_match;
  logic                    store_en;
  logic                    clear_all;
  logic                    drain_clr;
  logic                    exp_en;
  logic [SEQ_W-1:0]        exp_val;
  logic                    ram_rd_en;
  logic [SLOT_W-1:0]       res_slot;
  logic [SLOT_W+IDX_W-1:0] slot_ext;
  logic                    exp_quiet;

  // Compare every slot cell against the current key
  assign cmp_key = (state == rrae_pkg::ENG_CHECK) ? cur_seq : expected_seq;

  always_comb begin
    for (int i = 0; i < BUFFER_SLOTS; i++) begin
      match[i] = slot_valid[i] && (slot_seq[i] == cmp_key);
    end
  end

  // Lowest-numbered hit and lowest free slot
  always_comb begin
    first_hit  = '0;
    first_free = '0;
    for (int i = BUFFER_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        first_hit = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        first_free = SLOT_W'(i);
      end
    end
  end

  assign any_free = !(&slot_valid);

  // Slot lengths
  rrae_ram #(
    .WIDTH(LEN_W),
    .DEPTH(BUFFER_SLOTS)
  ) u_len_ram (
    .clk    (clk),
    .wr_en  (store_en),
    .wr_addr(first_free),
    .wr_data(cur_len),
    .rd_en  (ram_rd_en),
    .rd_addr(first_hit),
    .rd_data(ram_len)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrae_pkg::ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next  = state;
    mid_pop     = 1'b0;
    latch_item  = 1'b0;
    latch_match = 1'b0;
    store_en    = 1'b0;
    clear_all   = 1'b0;
    drain_clr   = 1'b0;
    exp_en      = 1'b0;
    exp_val     = expected_seq;
    ram_rd_en   = 1'b0;
    out_push    = 1'b0;
    res_slot    = '0;
    out_res     = '0;
    case (state)
      rrae_pkg::ENG_IDLE: begin
        if (!mid_empty) begin
          mid_pop    = 1'b1;
          latch_item = 1'b1;
          state_next = rrae_pkg::ENG_CHECK;
        end
      end
      rrae_pkg::ENG_CHECK: begin
        latch_match = 1'b1;
        state_next  = rrae_pkg::ENG_DECIDE;
      end
      rrae_pkg::ENG_DECIDE: begin
        if (!out_full) begin
          out_push = 1'b1;
          if (cur_final) begin
            out_res.action     = rrae_pkg::ACT_FINAL;
            out_res.ack_number = cur_seq;
            out_res.last       = 1'b1;
            clear_all          = 1'b1;
            state_next         = rrae_pkg::ENG_IDLE;
          end else if (!is_eq) begin
            out_res.action     = rrae_pkg::ACT_ACK;
            out_res.ack_number = expected_seq;
            out_res.last       = 1'b1;
            if (is_stale) begin
              out_res.store_status = rrae_pkg::ST_STALE;
            end else if (|hit_vec) begin
              out_res.store_status = rrae_pkg::ST_DUP;
              res_slot             = first_hit;
            end else if (any_free) begin
              out_res.store_status = rrae_pkg::ST_STORED;
              res_slot             = first_free;
              store_en             = 1'b1;
            end else begin
              out_res.store_status = rrae_pkg::ST_FULL;
            end
            state_next = rrae_pkg::ENG_IDLE;
          end else begin
            out_res.action         = rrae_pkg::ACT_DELIVER_IN;
            out_res.deliver_offset = cur_seq;
            out_res.deliver_length = cur_len;
            exp_en                 = 1'b1;
            exp_val                = expected_seq + {{(SEQ_W-LEN_W){1'b0}}, cur_len};
            state_next             = rrae_pkg::ENG_SEARCH;
          end
        end
      end
      rrae_pkg::ENG_SEARCH: begin
        latch_match = 1'b1;
        state_next  = rrae_pkg::ENG_PICK;
      end
      rrae_pkg::ENG_PICK: begin
        if (|hit_vec) begin
          ram_rd_en  = 1'b1;
          state_next = rrae_pkg::ENG_DRAIN;
        end else begin
          state_next = rrae_pkg::ENG_ACK;
        end
      end
      rrae_pkg::ENG_DRAIN: begin
        if (!out_full) begin
          out_push               = 1'b1;
          out_res.action         = rrae_pkg::ACT_DELIVER_SLOT;
          out_res.deliver_offset = expected_seq;
          out_res.deliver_length = ram_len;
          res_slot               = hit_idx;
          exp_en                 = 1'b1;
          exp_val                = expected_seq + {{(SEQ_W-LEN_W){1'b0}}, ram_len};
          drain_clr              = 1'b1;
          state_next             = rrae_pkg::ENG_SEARCH;
        end
      end
      rrae_pkg::ENG_ACK: begin
        if (!out_full) begin
          out_push           = 1'b1;
          out_res.action     = rrae_pkg::ACT_ACK;
          out_res.ack_number = expected_seq;
          out_res.last       = 1'b1;
          state_next         = rrae_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_next = rrae_pkg::ENG_IDLE;
      end
    endcase
    // Fit the slot number to the result field
    slot_ext           = {{IDX_W{1'b0}}, res_slot};
    out_res.slot_index = slot_ext[IDX_W-1:0];
  end

  // Hold the header being worked on
  always_ff @(posedge clk) begin
    if (latch_item) begin
      cur_seq   <= mid_item.seq;
      cur_len   <= mid_item.len;
      cur_final <= mid_item.is_final;
    end
  end

  // Register search results
  always_ff @(posedge clk) begin
    if (latch_match) begin
      hit_vec  <= match;
      is_eq    <= (cur_seq == expected_seq);
      is_stale <= (cur_seq < expected_seq);
    end
    if (ram_rd_en) begin
      hit_idx <= first_hit;
    end
  end

  // Slot cells
  always_ff @(posedge clk) begin
    if (store_en) begin
      slot_seq[first_free] <= cur_seq;
    end
  end

  // Expected offset and slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= '0;
      slot_valid   <= '0;
    end else if (clear_all) begin
      expected_seq <= '0;
      slot_valid   <= '0;
    end else begin
      if (exp_en) begin
        expected_seq <= exp_val;
      end
      if (store_en) begin
        slot_valid[first_free] <= 1'b1;
      end
      if (drain_clr) begin
        slot_valid[hit_idx] <= 1'b0;
      end
    end
  end

  // States that never move the expected offset
  assign exp_quiet = state inside {rrae_pkg::ENG_CHECK, rrae_pkg::ENG_SEARCH,
                                   rrae_pkg::ENG_PICK, rrae_pkg::ENG_ACK};

  `ASSERT_NEXT(a_last_ends_item, out_push && out_res.last, state == rrae_pkg::ENG_IDLE)
  `ASSERT_IMPL(a_drain_slot_held, state == rrae_pkg::ENG_DRAIN, slot_valid[hit_idx])
  `ASSERT_NEXT(a_exp_only_on_delivery, exp_quiet, $stable(expected_seq))

endmodule
